FILE: hdl/assert_macros.svh
// assertion macros used by the list core sequencer, bvie_ctrl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// trigger implies condition in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed");

// trigger implies condition in the next cycle
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");

`endif

FILE: hdl/bvie_pkg.sv
// shared types and constants of the bounded list core
// no dependencies
package bvie_pkg;

   localparam int CAPACITY_DEF  = 32;
   localparam int WORD_BITS_DEF = 32;

   localparam int TYPE_BITS   = 4;
   localparam int POS_BITS    = 6;
   localparam int VALUE_BITS  = 32;
   localparam int LEN_BITS    = 6;
   localparam int STATUS_BITS = 2;

   typedef enum logic [TYPE_BITS-1:0] {
      OP_PUSH   = 4'd0,
      OP_POP    = 4'd1,
      OP_INSERT = 4'd2,
      OP_ERASE  = 4'd3,
      OP_RANGE  = 4'd4,
      OP_READ   = 4'd5,
      OP_BACK   = 4'd6,
      OP_CLEAR  = 4'd7,
      OP_RESIZE = 4'd8
   } op_type;

   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_BAD   = 2'd3;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status_code;
      logic [LEN_BITS-1:0]    length_now;
      logic [VALUE_BITS-1:0]  read_value;
   } rsp_type;

endpackage

FILE: hdl/bvie_store.sv
// word store of the list core: one write port, one read port, registered read
// depends on bvie_pkg
module bvie_store #(
   parameter int CAPACITY  = bvie_pkg::CAPACITY_DEF,
   parameter int WORD_BITS = bvie_pkg::WORD_BITS_DEF,
   parameter int AW        = $clog2(CAPACITY)
) (
   input  logic                 clock,
   input  bvie_pkg::mem_ctl_type mem_ctl,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic [AW-1:0]        rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [CAPACITY];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/bvie_ctrl.sv
// operation sequencer of the list core: length count, shift loops, clearing pass
// depends on bvie_pkg and assert_macros.svh
`include "assert_macros.svh"

module bvie_ctrl #(
   parameter int CAPACITY  = bvie_pkg::CAPACITY_DEF,
   parameter int WORD_BITS = bvie_pkg::WORD_BITS_DEF,
   parameter int AW        = $clog2(CAPACITY)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bvie_pkg::op_type                     req_op,
   input  logic [bvie_pkg::POS_BITS-1:0]        position,
   input  logic [bvie_pkg::POS_BITS-1:0]        end_position,
   input  logic [bvie_pkg::VALUE_BITS-1:0]      item_value,
   input  logic                                 slot_free,
   output logic                                 res_strobe,
   output bvie_pkg::rsp_type                    res,
   output bvie_pkg::mem_ctl_type                mem_ctl,
   output logic [AW-1:0]                        wr_addr,
   output logic [WORD_BITS-1:0]                 wr_data,
   output logic [AW-1:0]                        rd_addr,
   input  logic [WORD_BITS-1:0]                 rd_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > bvie_pkg::POS_BITS) ? CW + 1 : bvie_pkg::POS_BITS + 1;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_UP,
      S_FILL,
      S_DOWN,
      S_RDWAIT,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        src_ff, src_in;
   logic [AW-1:0]        dst_ff, dst_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        lim_ff, lim_in;
   logic [WORD_BITS-1:0] value_ff, value_in;
   bvie_pkg::rsp_type    res_ff, res_in;

   logic          accepted;
   logic [XW-1:0] pos_x;
   logic [XW-1:0] end_x;
   logic [XW-1:0] cnt_x;
   logic [XW-1:0] cap_x;
   logic [XW-1:0] next_src_x;

   assign req_ready  = (state_ff == S_IDLE);
   assign accepted   = req_valid && req_ready;
   assign pos_x      = XW'(position);
   assign end_x      = XW'(end_position);
   assign cnt_x      = XW'(count_ff);
   assign cap_x      = XW'(CAPACITY);
   assign next_src_x = XW'(src_ff) + XW'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      pos_in       = pos_ff;
      lim_in       = lim_ff;
      value_in     = value_ff;
      res_in       = res_ff;
      mem_ctl      = '0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr      = '0;
      res_strobe   = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = src_ff;
            src_in        = src_ff + AW'(1);
            if (src_ff == AW'(CAPACITY - 1)) begin
               src_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accepted) begin
               res_in.read_value  = '0;
               res_in.status_code = bvie_pkg::ST_OK;
               state_in           = S_DONE;
               unique case (req_op)
                  bvie_pkg::OP_PUSH: begin
                     if (cnt_x >= cap_x) begin
                        res_in.status_code = bvie_pkg::ST_FULL;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = count_ff[AW-1:0];
                        wr_data       = WORD_BITS'(item_value);
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  bvie_pkg::OP_POP: begin
                     if (cnt_x == '0) begin
                        res_in.status_code = bvie_pkg::ST_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  bvie_pkg::OP_INSERT: begin
                     if (pos_x >= cnt_x) begin
                        res_in.status_code = bvie_pkg::ST_BAD;
                     end else if (cnt_x >= cap_x) begin
                        res_in.status_code = bvie_pkg::ST_FULL;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = AW'(cnt_x - XW'(1));
                        src_in        = AW'(cnt_x - XW'(1));
                        pos_in        = pos_x[AW-1:0];
                        value_in      = WORD_BITS'(item_value);
                        count_in      = count_ff + CW'(1);
                        state_in      = S_UP;
                     end
                  end
                  bvie_pkg::OP_ERASE: begin
                     if (cnt_x == '0) begin
                        res_in.status_code = bvie_pkg::ST_EMPTY;
                     end else if (pos_x >= cnt_x) begin
                        res_in.status_code = bvie_pkg::ST_BAD;
                     end else begin
                        count_in = count_ff - CW'(1);
                        if (pos_x + XW'(1) < cnt_x) begin
                           mem_ctl.rd_en = 1'b1;
                           rd_addr       = AW'(pos_x + XW'(1));
                           src_in        = AW'(pos_x + XW'(1));
                           dst_in        = pos_x[AW-1:0];
                           lim_in        = count_ff;
                           state_in      = S_DOWN;
                        end
                     end
                  end
                  bvie_pkg::OP_RANGE: begin
                     if (cnt_x == '0) begin
                        res_in.status_code = bvie_pkg::ST_EMPTY;
                     end else if (!(pos_x < end_x && end_x < cnt_x)) begin
                        res_in.status_code = bvie_pkg::ST_BAD;
                     end else begin
                        count_in      = CW'(cnt_x - (end_x - pos_x));
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = end_x[AW-1:0];
                        src_in        = end_x[AW-1:0];
                        dst_in        = pos_x[AW-1:0];
                        lim_in        = count_ff;
                        state_in      = S_DOWN;
                     end
                  end
                  bvie_pkg::OP_READ: begin
                     if (pos_x >= cnt_x) begin
                        res_in.status_code = bvie_pkg::ST_BAD;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = pos_x[AW-1:0];
                        state_in      = S_RDWAIT;
                     end
                  end
                  bvie_pkg::OP_BACK: begin
                     if (cnt_x == '0) begin
                        res_in.status_code = bvie_pkg::ST_EMPTY;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = AW'(cnt_x - XW'(1));
                        state_in      = S_RDWAIT;
                     end
                  end
                  bvie_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  bvie_pkg::OP_RESIZE: begin
                     if (pos_x > cap_x) begin
                        res_in.status_code = bvie_pkg::ST_BAD;
                     end else begin
                        count_in = CW'(pos_x);
                     end
                  end
                  default: begin
                     res_in.status_code = bvie_pkg::ST_BAD;
                  end
               endcase
               res_in.length_now = bvie_pkg::LEN_BITS'(count_in);
            end
         end
         S_UP: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = src_ff + AW'(1);
            wr_data       = rd_data;
            if (src_ff == pos_ff) begin
               state_in = S_FILL;
            end else begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = src_ff - AW'(1);
               src_in        = src_ff - AW'(1);
            end
         end
         S_FILL: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = pos_ff;
            wr_data       = value_ff;
            state_in      = S_DONE;
         end
         S_DOWN: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = dst_ff;
            wr_data       = rd_data;
            dst_in        = dst_ff + AW'(1);
            if (next_src_x < XW'(lim_ff)) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = next_src_x[AW-1:0];
               src_in        = next_src_x[AW-1:0];
            end else begin
               state_in = S_DONE;
            end
         end
         S_RDWAIT: begin
            res_in.read_value = bvie_pkg::VALUE_BITS'(rd_data);
            state_in          = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               res_strobe = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         count_ff <= '0;
         src_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         src_ff   <= src_in;
      end
      dst_ff   <= dst_in;
      pos_ff   <= pos_in;
      lim_ff   <= lim_in;
      value_ff <= value_in;
      res_ff   <= res_in;
   end

   assign res = res_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, XW'(count_ff) <= cap_x)
   `ASSERT_NEXT(a_one_item, clock, reset, accepted, !req_ready)
   `ASSERT_IMPLIES(a_strobe_slot, clock, reset, res_strobe, slot_free && !req_ready)
   `ASSERT_NEXT(a_push_grows, clock, reset, accepted && req_op == bvie_pkg::OP_PUSH && cnt_x < cap_x, count_ff == $past(count_ff) + CW'(1))

endmodule

FILE: hdl/bounded_vector_insert_erase_core.sv
// channel   dir  handshake                 payload
// req       in   req_tvalid / req_tready   req_tuser op, req_tdata position/end/value
// rsp       out  rsp_tvalid / rsp_tready   rsp_tdata value/length/status
//
// one item at a time through a single-port-write, single-port-read word store
// push, pop, clear, resize and rejected items go straight to S_DONE; read and back
// pass S_RDWAIT; insert shifts up in S_UP, then writes the value in S_FILL; erase
// shifts down in S_DOWN; the moves run one word a cycle through the store's read
// and write ports; after reset a clearing pass zeroes the store, req_tready low
// a held result does not block acceptance; the next result waits in the sequencer
module bounded_vector_insert_erase_core #(
   parameter int CAPACITY  = bvie_pkg::CAPACITY_DEF,
   parameter int WORD_BITS = bvie_pkg::WORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // position[5:0], end_position[11:6], item_value[43:12]
   input  logic [3:0]  req_tuser,   // req_type[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // read_value[31:0], length_now[37:32], status_code[39:38]
);

   localparam int AW = $clog2(CAPACITY);

   bvie_pkg::mem_ctl_type mem_ctl;
   bvie_pkg::rsp_type     res;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [WORD_BITS-1:0]  wr_data;
   logic [WORD_BITS-1:0]  rd_data;
   logic                  res_strobe;
   logic                  slot_free;

   logic                  rsp_valid_ff, rsp_valid_in;
   bvie_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_strobe) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   bvie_ctrl #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS),
      .AW        (AW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_op       (bvie_pkg::op_type'(req_tuser)),
      .position     (req_tdata[5:0]),
      .end_position (req_tdata[11:6]),
      .item_value   (req_tdata[43:12]),
      .slot_free    (slot_free),
      .res_strobe   (res_strobe),
      .res          (res),
      .mem_ctl      (mem_ctl),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data)
   );

   bvie_store #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS),
      .AW        (AW)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
